/* src/fpfs_pkg.sv */
// ----------------------------------------------------------------------------
// Frame pacer package
// Shared widths, command codes, register indexes and control structs for the
// fixed-step frame pacer.
// ----------------------------------------------------------------------------
`default_nettype none

package fpfs_pkg;

    localparam int DELTA_W     = 24;
    localparam int STEP_W      = 20;
    localparam int CAP_W       = 8;
    localparam int RAW_W       = 28;
    localparam int CMD_W       = 2;
    localparam int WORD_W      = 32;
    localparam int PROD_W      = 60;
    localparam int DEN_W       = 31;
    localparam int DIV_CNT_W   = 5;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 96;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;

    // Length of the frame-rate window in microseconds.
    localparam logic [WORD_W-1:0] RATE_WINDOW_US = 32'd500000;
    // 256 (Q8) times one million microseconds per second.
    localparam logic [RAW_W-1:0]  FPS_SCALE      = 28'd256000000;

    localparam logic [DELTA_W-1:0] MAX_DELTA_RST = 24'd250000;
    localparam logic [STEP_W-1:0]  FIXED_STEP_RST = 20'd16667;
    localparam logic [CAP_W-1:0]   MAX_STEPS_RST = 8'd5;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 2'd0,
        CMD_STEP    = 2'd1,
        CMD_RESTART = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_DELTA  = 2'd0,
        CFG_FIXED_STEP = 2'd1,
        CFG_MAX_STEPS  = 2'd2
    } t_cfg_idx;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic exec;
        logic mul;
        logic div_start;
        logic load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic rate_due;
        logic div_done;
    } t_dp_sts;

endpackage

`default_nettype wire

/* src/fpfs_div.sv */
// ----------------------------------------------------------------------------
// Frame pacer divider
// Restoring radix-2 divider, one quotient bit per cycle, with the quotient
// saturated to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module fpfs_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [fpfs_pkg::PROD_W-1:0]   i_num,
    input  wire logic [fpfs_pkg::DEN_W-1:0]    i_den,
    output logic                               o_done,
    output logic [fpfs_pkg::WORD_W-1:0]        o_quot
);
    import fpfs_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0]     r_rem;
    logic [DEN_W-1:0]     r_den;
    logic [WORD_W-1:0]    r_q;
    logic                 r_sat;

    logic [WORD_W-1:0]    shifted;
    logic [WORD_W-1:0]    diff;
    logic                 ge;
    logic [DEN_W-1:0]     n_rem;
    logic [DEN_W-1:0]     num_hi;

    always_comb begin
        shifted = {r_rem, r_q[WORD_W-1]};
        ge      = shifted >= {1'b0, r_den};
        diff    = shifted - {1'b0, r_den};
        n_rem   = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        num_hi  = DEN_W'(i_num[PROD_W-1:WORD_W]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '1;
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // The upper numerator half starts as the remainder; if it already reaches
    // the divisor, the quotient cannot fit in 32 bits.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= num_hi;
            r_q   <= i_num[WORD_W-1:0];
            r_den <= i_den;
            r_sat <= num_hi >= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= {r_q[WORD_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_sat ? '1 : r_q;

endmodule

`default_nettype wire

/* src/fpfs_datapath.sv */
// ----------------------------------------------------------------------------
// Frame pacer datapath
// Configuration registers, timing state, tick and step arithmetic, the rate
// multiplier and divider, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fpfs_datapath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire fpfs_pkg::t_dp_cmd                 i_cmd,
    output fpfs_pkg::t_dp_sts                      o_sts,
    input  wire logic [fpfs_pkg::IN_TDATA_W-1:0]   i_s_data,
    input  wire logic [fpfs_pkg::CMD_W-1:0]        i_s_user,
    input  wire logic                              i_cfg_we,
    input  wire logic [fpfs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [fpfs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic [fpfs_pkg::OUT_TDATA_W-1:0]       o_m_data,
    output logic                                   o_m_user
);
    import fpfs_pkg::*;

    // Configuration.
    logic [DELTA_W-1:0] r_max_delta;
    logic [STEP_W-1:0]  r_fixed_step;
    logic [CAP_W-1:0]   r_max_steps;

    // Latched item.
    t_cmd               r_cmd;
    logic [RAW_W-1:0]   r_raw;

    // Timing state.
    logic [DELTA_W-1:0] r_clamped, n_clamped;
    logic [WORD_W-1:0]  r_acc, n_acc;
    logic [WORD_W-1:0]  r_frames, n_frames;
    logic [WORD_W-1:0]  r_wt, n_wt;
    logic [WORD_W-1:0]  r_wf, n_wf;
    logic [WORD_W-1:0]  r_frame_rate, n_frame_rate;
    logic [CAP_W-1:0]   r_steps_cur, n_steps_cur;
    logic [CAP_W-1:0]   r_steps_prev, n_steps_prev;
    logic               r_granted, n_granted;

    // Rate computation.
    logic [WORD_W-1:0]  r_rate_frames, n_rate_frames;
    logic [DEN_W-1:0]   r_rate_den, n_rate_den;
    logic [PROD_W-1:0]  r_prod;

    // Result register.
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                   r_out_user;

    logic                   div_done;
    logic [WORD_W-1:0]      div_quot;

    logic [WORD_W:0]        wt_sum;
    logic [WORD_W-1:0]      wt_sat;
    logic [WORD_W-1:0]      wf_inc;
    logic [DELTA_W-1:0]     tick_clamped;
    logic [WORD_W:0]        acc_sum;
    logic                   window_full;

    fpfs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_prod),
        .i_den   (r_rate_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Tick arithmetic, evaluated from the current state.
    always_comb begin
        if (r_raw[RAW_W-1]) begin
            tick_clamped = '0;
        end else if (r_raw[RAW_W-2:0] > (RAW_W-1)'(r_max_delta)) begin
            tick_clamped = r_max_delta;
        end else begin
            tick_clamped = r_raw[DELTA_W-1:0];
        end

        wt_sum = {r_wt[WORD_W-1], r_wt} + (WORD_W+1)'(signed'(r_raw));
        if (wt_sum[WORD_W] != wt_sum[WORD_W-1]) begin
            wt_sat = wt_sum[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}}
                                    : {1'b0, {(WORD_W-1){1'b1}}};
        end else begin
            wt_sat = wt_sum[WORD_W-1:0];
        end
        wf_inc      = (r_wf == '1) ? r_wf : r_wf + 1'b1;
        window_full = !wt_sat[WORD_W-1] && (wt_sat >= RATE_WINDOW_US);
        acc_sum     = {1'b0, r_acc} + (WORD_W+1)'(tick_clamped);
    end

    always_comb begin
        n_clamped     = r_clamped;
        n_acc         = r_acc;
        n_frames      = r_frames;
        n_wt          = r_wt;
        n_wf          = r_wf;
        n_frame_rate  = r_frame_rate;
        n_steps_cur   = r_steps_cur;
        n_steps_prev  = r_steps_prev;
        n_granted     = r_granted;
        n_rate_frames = r_rate_frames;
        n_rate_den    = r_rate_den;

        if (i_cmd.exec) begin
            n_granted = 1'b0;
            unique case (r_cmd)
                CMD_TICK: begin
                    n_clamped    = tick_clamped;
                    n_frames     = r_frames + 1'b1;
                    n_acc        = acc_sum[WORD_W] ? '1 : acc_sum[WORD_W-1:0];
                    n_steps_prev = r_steps_cur;
                    n_steps_cur  = '0;
                    if (window_full) begin
                        n_rate_frames = wf_inc;
                        n_rate_den    = wt_sat[DEN_W-1:0];
                        n_wt          = '0;
                        n_wf          = '0;
                    end else begin
                        n_wt = wt_sat;
                        n_wf = wf_inc;
                    end
                end
                CMD_STEP: begin
                    if (r_acc >= WORD_W'(r_fixed_step)) begin
                        if (r_steps_cur >= r_max_steps) begin
                            n_acc = '0;
                        end else begin
                            n_acc       = r_acc - WORD_W'(r_fixed_step);
                            n_steps_cur = r_steps_cur + 1'b1;
                            n_granted   = 1'b1;
                        end
                    end
                end
                CMD_RESTART: begin
                    n_clamped    = '0;
                    n_acc        = '0;
                    n_frames     = '0;
                    n_wt         = '0;
                    n_wf         = '0;
                    n_frame_rate = '0;
                    n_steps_cur  = '0;
                    n_steps_prev = '0;
                end
                default: begin
                end
            endcase
        end

        if (div_done) begin
            n_frame_rate = div_quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_delta  <= MAX_DELTA_RST;
            r_fixed_step <= FIXED_STEP_RST;
            r_max_steps  <= MAX_STEPS_RST;
            r_clamped    <= '0;
            r_acc        <= '0;
            r_frames     <= '0;
            r_wt         <= '0;
            r_wf         <= '0;
            r_frame_rate <= '0;
            r_steps_cur  <= '0;
            r_steps_prev <= '0;
            r_granted    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MAX_DELTA:  r_max_delta  <= i_cfg_data;
                    CFG_FIXED_STEP: r_fixed_step <= i_cfg_data[STEP_W-1:0];
                    CFG_MAX_STEPS:  r_max_steps  <= i_cfg_data[CAP_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_clamped    <= n_clamped;
            r_acc        <= n_acc;
            r_frames     <= n_frames;
            r_wt         <= n_wt;
            r_wf         <= n_wf;
            r_frame_rate <= n_frame_rate;
            r_steps_cur  <= n_steps_cur;
            r_steps_prev <= n_steps_prev;
            r_granted    <= n_granted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd <= t_cmd'(i_s_user);
            r_raw <= i_s_data[RAW_W-1:0];
        end
        r_rate_frames <= n_rate_frames;
        r_rate_den    <= n_rate_den;
        if (i_cmd.mul) begin
            r_prod <= r_rate_frames * FPS_SCALE;
        end
        if (i_cmd.load_out) begin
            r_out_data <= {r_steps_prev, r_frames, r_frame_rate, r_clamped};
            r_out_user <= r_granted;
        end
    end

    assign o_sts.rate_due = (r_cmd == CMD_TICK) && window_full;
    assign o_sts.div_done = div_done;
    assign o_m_data       = r_out_data;
    assign o_m_user       = r_out_user;

endmodule

`default_nettype wire

/* src/fpfs_ctrl.sv */
// ----------------------------------------------------------------------------
// Frame pacer controller
// Sequences acceptance, execution, the optional rate division and the
// hand-over into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fpfs_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_valid,
    output logic                    o_s_ready,
    output logic                    o_m_valid,
    input  wire logic               i_m_ready,
    output fpfs_pkg::t_dp_cmd       o_cmd,
    input  wire fpfs_pkg::t_dp_sts  i_sts
);
    import fpfs_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_EXEC = 6'b000010,
        ST_MUL  = 6'b000100,
        ST_LOAD = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_DONE = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_m_valid, n_m_valid;
    logic   out_free;

    assign out_free = !r_m_valid || i_m_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.rate_due ? ST_MUL : ST_DONE;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_LOAD;
            end
            ST_LOAD: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV;
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_m_valid = (r_m_valid && !i_m_ready) || o_cmd.load_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_s_ready = (r_state == ST_IDLE);
    assign o_m_valid = r_m_valid;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_valid && o_s_ready) |=> (r_state == ST_EXEC))
        else $error("accepted item did not start execution");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_m_valid || i_m_ready))
        else $error("result register overwritten while still held");

    a_div_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && !i_sts.div_done) |=> (r_state == ST_DIV))
        else $error("left division before the quotient was ready");

    a_div_only_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside the division state");

endmodule

`default_nettype wire

/* src/frame_pacer_fixed_step_core.sv */
// ----------------------------------------------------------------------------
// Frame pacer, fixed-step core
// Step requests, restarts and ticks without a rate update pass the execute and
// done states; a new item is accepted only once the last result is loaded.
// A tick that closes the rate window also passes the multiply, divider-start
// and division states, the serial divider producing one quotient bit per cycle.
// Synchronous active-low reset clears all timing state and loads the
// configuration defaults; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_pacer_fixed_step_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // tdata: raw_delta_us [27:0], zero padding [31:28]
    input  wire logic [fpfs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // tuser: command [1:0]
    input  wire logic [fpfs_pkg::CMD_W-1:0]          s_axis_tuser,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // tdata: delta_us [23:0], fps_q8 [55:24], frame_count [87:56],
    //        steps_last_frame [95:88]
    output logic [fpfs_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    // tuser: step_granted [0]
    output logic                                     m_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [fpfs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [fpfs_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import fpfs_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    assign o_cfg_ready = 1'b1;

    fpfs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_cmd     (dp_cmd),
        .i_sts     (dp_sts)
    );

    fpfs_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_s_data    (s_axis_tdata),
        .i_s_user    (s_axis_tuser),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_m_data    (m_axis_tdata),
        .o_m_user    (m_axis_tuser)
    );

endmodule

`default_nettype wire
